// ----- hdl/cpai_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the complex polar and inverse pipeline.
// Depends on nothing; imported by complex_polar_and_inverse and its checker.
package cpai_pkg;

    // Vector width for the angle engine and accumulator width in Q3.21
    localparam int XW = 44;
    localparam int AW = 26;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [AW-1:0] PI_Q21      = 26'sd6588397;
    localparam logic signed [AW-1:0] PHASE_LIMIT = 26'sd25736;
    localparam logic        [15:0]   MAG_LIMIT   = 16'd46341;

    // Arctangent of 2^-k in Q3.21 radians
    localparam logic signed [AW-1:0] ATAN_Q21 [ATAN_ENTRIES] = '{
        26'sd1647099, 26'sd972340, 26'sd513757, 26'sd260791,
        26'sd130902,  26'sd65515,  26'sd32765,  26'sd16384,
        26'sd8192,    26'sd4096,   26'sd2048,   26'sd1024,
        26'sd512,     26'sd256,    26'sd128,    26'sd64,
        26'sd32,      26'sd16,     26'sd8,      26'sd4,
        26'sd2,       26'sd1,      26'sd0,      26'sd0
    };

    // Payload carried by each pipeline stage
    typedef struct packed {
        logic [15:0]          abs_r;
        logic [15:0]          abs_i;
        logic                 rr_neg;
        logic                 ri_neg;
        logic                 zero;
        logic                 neg_sat;
        logic [15:0]          neg_r;
        logic [15:0]          neg_i;
        logic [31:0]          sq_r;
        logic [31:0]          sq_i;
        logic [31:0]          srem;
        logic [15:0]          sroot;
        logic [32:0]          den;
        logic [34:0]          rem_r;
        logic [34:0]          rem_i;
        logic [16:0]          quo_r;
        logic [16:0]          quo_i;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
    } t_stage;

endpackage

// ----- hdl/complex_polar_and_inverse.sv -----
// Takes one request per cycle while the output is not stalled; the square root, both reciprocal dividers and
// the angle rotations each retire one bit or one micro-rotation per stage.
// Bubbles are squeezed out when the output stalls; a full pipeline holds its items.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data is not reset.
// Top level: polar form, reciprocal and negation of a Q8.8 complex number.
// Depends on cpai_pkg.
`timescale 1ns / 1ps
module complex_polar_and_inverse
    import cpai_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // real_part [15:0], imag_part [31:16]
    input  logic [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // magnitude [15:0], phase [31:16], recip_real [47:32], recip_imag [63:48],
    // neg_real [79:64], neg_imag [95:80], conj_imag [111:96]
    output logic [111:0] m_axis_tdata,
    // zero_input [0], saturated [1]
    output logic [1:0]   m_axis_tuser
);

    localparam int NS = (ANGLE_ITERATIONS + 1 > 20) ? ANGLE_ITERATIONS + 1 : 20;

    t_stage         r_st  [1:NS];
    t_stage         n_st  [1:NS];
    t_stage         n_head;
    logic           r_vld [1:NS];
    logic           adv   [1:NS+1];
    logic           r_out_vld;
    logic [111:0]   r_tdata;
    logic [1:0]     r_tuser;
    logic [111:0]   n_tdata;
    logic [1:0]     n_tuser;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        adv[NS+1] = !r_out_vld || m_axis_tready;
        for (int k = NS; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[1];

    // Stage one: unpack, take magnitudes and negations, pre-rotate the vector
    always_comb begin
        logic [15:0]          re;
        logic [15:0]          im;
        logic signed [XW-1:0] xv;
        logic signed [XW-1:0] yv;
        re = s_axis_tdata[15:0];
        im = s_axis_tdata[31:16];
        xv = $signed({{4{re[15]}}, re, 24'b0});
        yv = $signed({{4{im[15]}}, im, 24'b0});
        n_head         = '0;
        n_head.abs_r   = re[15] ? (~re + 16'd1) : re;
        n_head.abs_i   = im[15] ? (~im + 16'd1) : im;
        n_head.rr_neg  = re[15];
        n_head.ri_neg  = !im[15] && (im != 16'd0);
        n_head.zero    = (re == 16'd0) && (im == 16'd0);
        n_head.neg_r   = (re == 16'h8000) ? 16'h7FFF : (~re + 16'd1);
        n_head.neg_i   = (im == 16'h8000) ? 16'h7FFF : (~im + 16'd1);
        n_head.neg_sat = (re == 16'h8000) || (im == 16'h8000);
        if (re[15]) begin
            n_head.x   = -xv;
            n_head.y   = -yv;
            n_head.ang = im[15] ? -PI_Q21 : PI_Q21;
        end else begin
            n_head.x   = xv;
            n_head.y   = yv;
            n_head.ang = '0;
        end
    end

    // Later stages: squares, sum, one root bit, one quotient bit, one rotation
    always_comb begin
        t_stage               p;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic [32:0]          tt;
        logic [49:0]          dsh;
        logic [31:0]          ssum;
        int                   j;
        n_st[1] = n_head;
        for (int k = 2; k <= NS; k++) begin
            p = r_st[k-1];
            // square both parts
            if (k == 2) begin
                p.sq_r = 32'(p.abs_r * p.abs_r);
                p.sq_i = 32'(p.abs_i * p.abs_i);
            end
            // sum of squares feeds the root and both dividers
            if (k == 3) begin
                ssum    = p.sq_r + p.sq_i;
                p.srem  = ssum;
                p.sroot = '0;
                p.den   = {ssum, 1'b0};
                p.rem_r = 35'({p.abs_r, 17'b0}) + 35'(ssum);
                p.rem_i = 35'({p.abs_i, 17'b0}) + 35'(ssum);
                p.quo_r = '0;
                p.quo_i = '0;
            end
            // restoring square root, one bit per stage
            if (k >= 4 && k <= 19) begin
                j  = 19 - k;
                tt = ({17'b0, p.sroot} << (j + 1)) | (33'd1 << (2 * j));
                if ({1'b0, p.srem} >= tt) begin
                    p.srem     = p.srem - tt[31:0];
                    p.sroot[j] = 1'b1;
                end
            end
            // restoring reciprocal dividers, one quotient bit per stage
            if (k >= 4 && k <= 20) begin
                j   = 20 - k;
                dsh = {17'b0, p.den} << j;
                if ({15'b0, p.rem_r} >= dsh) begin
                    p.rem_r    = p.rem_r - dsh[34:0];
                    p.quo_r[j] = 1'b1;
                end
                if ({15'b0, p.rem_i} >= dsh) begin
                    p.rem_i    = p.rem_i - dsh[34:0];
                    p.quo_i[j] = 1'b1;
                end
            end
            // vectoring micro-rotation
            if (k >= 2 && k <= ANGLE_ITERATIONS + 1) begin
                j  = k - 2;
                xs = p.x >>> j;
                ys = p.y >>> j;
                if (!p.y[XW-1]) begin
                    p.x   = p.x + ys;
                    p.y   = p.y - xs;
                    p.ang = p.ang + ATAN_Q21[j];
                end else begin
                    p.x   = p.x - ys;
                    p.y   = p.y + xs;
                    p.ang = p.ang - ATAN_Q21[j];
                end
            end
            n_st[k] = p;
        end
    end

    // Stage registers
    for (genvar g = 1; g <= NS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (adv[g]) begin
                if (g == 1) begin
                    r_vld[g] <= s_axis_tvalid;
                end else begin
                    r_vld[g] <= r_vld[(g > 1) ? g - 1 : 1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv[g]) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    // Final stage: round the root, round and clip the angle and reciprocals
    always_comb begin
        t_stage               p;
        logic [15:0]          mag;
        logic signed [AW-1:0] tph;
        logic signed [AW-1:0] ph;
        logic [15:0]          phase;
        logic [15:0]          rr;
        logic [15:0]          ri;
        logic                 sr;
        logic                 si;
        p   = r_st[NS];
        mag = p.sroot + 16'(p.srem > {16'b0, p.sroot});
        tph = p.ang + 26'sd128;
        ph  = tph >>> 8;
        if (ph > PHASE_LIMIT) begin
            ph = PHASE_LIMIT;
        end else if (ph < -PHASE_LIMIT) begin
            ph = -PHASE_LIMIT;
        end
        phase = ph[15:0];
        // real part of the reciprocal
        sr = 1'b0;
        if (p.rr_neg) begin
            if (p.quo_r > 17'd32768) begin
                rr = 16'h8000;
                sr = 1'b1;
            end else begin
                rr = 16'(~p.quo_r + 17'd1);
            end
        end else if (p.quo_r > 17'd32767) begin
            rr = 16'h7FFF;
            sr = 1'b1;
        end else begin
            rr = p.quo_r[15:0];
        end
        // imaginary part of the reciprocal
        si = 1'b0;
        if (p.ri_neg) begin
            if (p.quo_i > 17'd32768) begin
                ri = 16'h8000;
                si = 1'b1;
            end else begin
                ri = 16'(~p.quo_i + 17'd1);
            end
        end else if (p.quo_i > 17'd32767) begin
            ri = 16'h7FFF;
            si = 1'b1;
        end else begin
            ri = p.quo_i[15:0];
        end
        // zero input forces angle and reciprocal to zero
        if (p.zero) begin
            phase = '0;
            rr    = '0;
            ri    = '0;
            sr    = 1'b0;
            si    = 1'b0;
        end
        n_tdata = {p.neg_i, p.neg_i, p.neg_r, ri, rr, phase, mag};
        n_tuser = {sr || si || p.neg_sat, p.zero};
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv[NS+1]) begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS+1]) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

    // A zero input must leave angle, reciprocal and modulus at zero
    a_zero_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
        else $error("zero input gave non-zero modulus, angle or reciprocal");

    // Modulus stays within the largest possible root
    a_mag_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] <= MAG_LIMIT)
        else $error("modulus out of range");

    // Angle stays within plus and minus pi
    a_phase_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd25736) &&
                          ($signed(m_axis_tdata[31:16]) >= -16'sd25736))
        else $error("angle out of range");

    // Input is held back only when the first stage is occupied
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_vld[1] && r_out_vld)
        else $error("input stalled with room in the pipeline");

endmodule

// ----- sim/complex_polar_and_inverse_checker.sv -----
`timescale 1ns / 1ps
// Result checker for complex_polar_and_inverse: watches both stream channels,
// predicts each result from the accepted request and compares the whole data word and flags.
// Depends on cpai_pkg for the arctangent table and angle constants.
module complex_polar_and_inverse_checker
    import cpai_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [31:0]  i_req_data,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [111:0] i_res_data,
    input  logic [1:0]   i_res_user,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_result_count
);

    typedef struct packed {
        logic [1:0]   flags;
        logic [111:0] data;
    } t_polar;

    t_polar polar_queue[$];
    int     mismatch_count;
    int     orphan_count;

    // Floor division by 2^s for signed values
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] clip16(longint v, ref logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sd32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    // Rounded 65536*num/den, ties away from zero
    function automatic longint recip_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0 ? -num : num) * 65536;
        q = (mag * 2 + den) / (den * 2);
        return num < 0 ? -q : q;
    endfunction

    function automatic logic signed [15:0] angle_of(longint re, longint im);
        longint x;
        longint y;
        longint ang;
        longint xs;
        longint ys;
        longint ph;
        int     n;
        x = re * 64'sd16777216;
        y = im * 64'sd16777216;
        ang = 0;
        n = ANGLE_ITERATIONS > ATAN_ENTRIES ? ATAN_ENTRIES : ANGLE_ITERATIONS;
        if (re < 0) begin
            ang = (im >= 0) ? longint'(PI_Q21) : -longint'(PI_Q21);
            x = -x;
            y = -y;
        end
        for (int k = 0; k < n; k++) begin
            xs = floor_shr(x, k);
            ys = floor_shr(y, k);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + longint'(ATAN_Q21[k]);
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - longint'(ATAN_Q21[k]);
            end
        end
        ph = floor_shr(ang + 128, 8);
        if (ph > longint'(PHASE_LIMIT)) ph = PHASE_LIMIT;
        if (ph < -longint'(PHASE_LIMIT)) ph = -longint'(PHASE_LIMIT);
        return ph[15:0];
    endfunction

    function automatic t_polar polar_of(logic [31:0] req);
        longint re;
        longint im;
        longint s;
        longint q;
        logic   sat;
        logic   zero;
        logic signed [15:0] ph;
        logic signed [15:0] rr;
        logic signed [15:0] ri;
        logic signed [15:0] nr;
        logic signed [15:0] ni;
        t_polar res;
        re = longint'($signed(req[15:0]));
        im = longint'($signed(req[31:16]));
        s = re * re + im * im;
        q = longint'($floor($sqrt(real'(s))));
        while (q * q > s) q--;
        while ((q + 1) * (q + 1) <= s) q++;
        if (s - q * q > q) q++;
        zero = (s == 0);
        sat = 1'b0;
        ph = '0;
        rr = '0;
        ri = '0;
        if (!zero) begin
            ph = angle_of(re, im);
            rr = clip16(recip_round(re, s), sat);
            ri = clip16(recip_round(-im, s), sat);
        end
        nr = clip16(-re, sat);
        ni = clip16(-im, sat);
        res.data = {ni, ni, nr, ri, rr, ph, q[15:0]};
        res.flags = {sat, zero};
        return res;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        t_polar want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) polar_queue.push_back(polar_of(i_req_data));
            if (i_res_valid && i_res_ready) begin
                o_result_count <= o_result_count + 1;
                if (polar_queue.size() == 0) begin
                    orphan_count++;
                    $display("unexpected result %h user %b", i_res_data, i_res_user);
                end else begin
                    want = polar_queue.pop_front();
                    if (want.data !== i_res_data || want.flags !== i_res_user) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: want data %h user %b, got data %h user %b",
                                     want.data, want.flags, i_res_data, i_res_user);
                    end
                end
            end
        end
    end

    initial begin
        mismatch_count = 0;
        orphan_count = 0;
        o_result_count = 0;
    end

    assign o_pending = polar_queue.size();
    assign o_fail_count = mismatch_count + orphan_count;

endmodule

// ----- sim/complex_polar_and_inverse_test.sv -----
`timescale 1ns / 1ps
// Top of the complex_polar_and_inverse testbench: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on the block and checker.
module complex_polar_and_inverse_test;

    localparam int LATENCY = 24;
    localparam int STALL_LIMIT = 4000;

    logic         i_clk;
    logic         i_rst_n;
    logic         req_valid;
    logic         req_ready;
    logic [31:0]  req_data;
    logic         res_valid;
    logic         res_ready;
    logic [111:0] res_data;
    logic [1:0]   res_user;
    int           fail_count;
    int           pending;
    int           result_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    int           quiet_cycles;

    complex_polar_and_inverse u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(req_valid),
        .s_axis_tready(req_ready),
        .s_axis_tdata (req_data),
        .m_axis_tvalid(res_valid),
        .m_axis_tready(res_ready),
        .m_axis_tdata (res_data),
        .m_axis_tuser (res_user)
    );

    complex_polar_and_inverse_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .i_res_user    (res_user),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Drive the receiver: long hold-off when asked, else random stalls
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run after a long stretch with no handshake
    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request, idling at random first, and hold until accepted
    task automatic send_number(logic signed [15:0] re, logic signed [15:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data <= {im, re};
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly full-range noise, with edge, tiny and moderate values mixed in
    function automatic logic [15:0] pick_part();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(6)) - 3);
            3, 4: return 16'($signed($urandom_range(1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] edge_vals [8];
        quiet_cycles = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_valid = 1'b0;
        req_data = '0;
        res_ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, axes, quadrants, most-negative values, tiny values
        edge_vals = '{16'sh0000, 16'sh0001, -16'sh0001, 16'sh7FFF,
                      -16'sh8000, 16'sh0100, -16'sh0100, 16'sh0080};
        for (int a = 0; a < 5; a++) begin
            for (int b = 0; b < 5; b++) send_number(edge_vals[a], edge_vals[b]);
        end

        // Random phases: no idling, sender idling, receiver stalls after a hold-off, then both
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 53 : 32) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? (p == 2 ? 53 : 32) : 0;
            if (p == 1) begin
                pause_until_drained();
            end
            if (p == 2) begin
                hold_off_cycles <= 200;
            end
            for (int n = 0; n < 245; n++) send_number(pick_part(), pick_part());
        end

        pause_until_drained();
        recv_stall_pct = 0;
        repeat (LATENCY) @(negedge i_clk);
        $display("Covered %0d results over edge values and four idling phases.", result_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
